// ----- rtl/rope_pkg.sv -----
// shared types, codes and rounding for the rotary position embedding core
package rope_pkg;

	typedef enum logic {
		ST_COLLECT,
		ST_ISSUE
	} state_t;

	typedef enum logic [1:0] {
		CFG_HEAD_LENGTH,
		CFG_ROTARY_PAIRS,
		CFG_INTERLEAVED,
		CFG_TABLE_ROWS
	} cfg_idx_t;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_DATA = 1'b1;

	localparam int CFG_W = 11;

	typedef struct packed {
		logic       rot;
		logic       first;
		logic       err;
		logic       last;
		logic [5:0] idx;
	} side_t;

	function automatic logic signed [15:0] round_sat(input logic signed [32:0] sum);
		logic signed [33:0] t;
		logic        [18:0] q;
		logic signed [15:0] r;
		t = $signed({sum[32], sum}) + 34'sd16384;
		q = t[33:15];
		if (!q[18] && (|q[17:15])) begin
			r = 16'sh7fff;
		end else if (q[18] && !(&q[17:15])) begin
			r = 16'sh8000;
		end else begin
			r = $signed(q[15:0]);
		end
		return r;
	endfunction

endpackage

// ----- rtl/rotary_position_embedding_core.sv -----
// rotary position embedding core: table load, row collection and rotated emission
//
// input channel (in_valid/in_stall): a word with action load writes one cos/sin
// pair of the tables at table_row/table_column; a word with action data adds
// one element of the current head row, and the first element of a row gives
// its row_position
// once the row holds its full length N, in_stall rises and the row is emitted
// on the output channel (out_valid/out_stall), one element a cycle while the
// receiver does not stall, index 0 first, last on element N-1
// after the final data word of a row is taken, the sequencer enters the issue
// state and each element passes the row store and table reads, the product
// registers and the output register; no new input words are taken while a row
// is emitted, since the row store is read back over its ports once per element
// while inputs are held off; load words are taken only while a row is collected
// when the receiver stalls, the whole emission pipeline freezes and the row
// store and table reads hold their data, so nothing is lost or repeated
// reset clears the row count, position and control and sets the registers to
// head length 64, 32 pairs, half-split pairing and 1024 valid rows; table and
// row store contents are undefined until written
module rotary_position_embedding_core #(
	parameter int MAX_HEAD   = 64,
	parameter int TABLE_ROWS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  rope_pkg::cfg_idx_t     cfg_index,
	input  logic [rope_pkg::CFG_W-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   action,
	input  logic [9:0]             table_row,
	input  logic [4:0]             table_column,
	input  logic signed [15:0]     cos_value,
	input  logic signed [15:0]     sin_value,
	input  logic signed [15:0]     x_value,
	input  logic [9:0]             row_position,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [15:0]     y_value,
	output logic [5:0]             element_index,
	output logic                   range_error,
	output logic                   last
);

	import rope_pkg::*;

	localparam int PAIR_COLS = MAX_HEAD / 2;
	localparam int TAB_DEPTH = TABLE_ROWS * PAIR_COLS;
	localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
	localparam int IDX_W     = $clog2(MAX_HEAD);
	localparam int LEN_W     = ($clog2(MAX_HEAD + 1) > 7) ? $clog2(MAX_HEAD + 1) : 7;

	// configuration
	logic [6:0]  head_length_q;
	logic [5:0]  rotary_pairs_q;
	logic        interleaved_q;
	logic [10:0] rows_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_length_q  <= 7'd64;
			rotary_pairs_q <= 6'd32;
			interleaved_q  <= 1'b0;
			rows_valid_q   <= 11'd1024;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HEAD_LENGTH:  head_length_q  <= cfg_data[6:0];
				CFG_ROTARY_PAIRS: rotary_pairs_q <= cfg_data[5:0];
				CFG_INTERLEAVED:  interleaved_q  <= cfg_data[0];
				CFG_TABLE_ROWS:   rows_valid_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// effective length and pair count
	logic [LEN_W-1:0] len_raw, eff_len, half_len, eff_pairs;

	always_comb begin
		len_raw = LEN_W'({head_length_q[6:1], 1'b0});
		if (len_raw < LEN_W'(2)) begin
			eff_len = LEN_W'(2);
		end else if (len_raw > LEN_W'(MAX_HEAD)) begin
			eff_len = LEN_W'(MAX_HEAD);
		end else begin
			eff_len = len_raw;
		end
		half_len = eff_len >> 1;
		if (rotary_pairs_q == 6'd0 || LEN_W'(rotary_pairs_q) > half_len) begin
			eff_pairs = half_len;
		end else begin
			eff_pairs = LEN_W'(rotary_pairs_q);
		end
	end

	// input side
	state_t           state_q, state_d;
	logic             adv, issue;
	logic             in_acc, data_acc, load_acc, row_done, tab_we;
	logic [LEN_W-1:0] cnt_q, cnt_inc;
	logic [9:0]       held_pos_q, cur_pos;
	logic             cur_err;
	logic [31:0]      tab_waddr_full;

	assign in_acc   = in_valid && !in_stall;
	assign data_acc = in_acc && (action == ACT_DATA);
	assign load_acc = in_acc && (action == ACT_LOAD);
	assign cnt_inc  = cnt_q + LEN_W'(1);
	assign row_done = data_acc && (cnt_inc >= eff_len);
	assign cur_pos  = (cnt_q == '0) ? row_position : held_pos_q;
	assign cur_err  = ({1'b0, cur_pos} >= rows_valid_q) || (32'(cur_pos) >= TABLE_ROWS);

	assign tab_we = load_acc && (32'(table_row) < TABLE_ROWS)
		&& (32'(table_column) < PAIR_COLS);
	assign tab_waddr_full = 32'(table_row) * 32'(PAIR_COLS) + 32'(table_column);

	// latched row context
	logic [LEN_W-1:0] len_q, pairs_q, k_q;
	logic             il_q, err_q;
	logic [9:0]       pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			held_pos_q <= '0;
			len_q      <= '0;
			pairs_q    <= '0;
			il_q       <= 1'b0;
			err_q      <= 1'b0;
			pos_q      <= '0;
			k_q        <= '0;
		end else begin
			if (data_acc && cnt_q == '0) begin
				held_pos_q <= row_position;
			end
			if (row_done) begin
				cnt_q   <= '0;
				len_q   <= eff_len;
				pairs_q <= eff_pairs;
				il_q    <= interleaved_q;
				err_q   <= cur_err;
				pos_q   <= cur_pos;
				k_q     <= '0;
			end else begin
				if (data_acc) begin
					cnt_q <= cnt_inc;
				end
				if (issue) begin
					k_q <= k_q + LEN_W'(1);
				end
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT: if (row_done) state_d = ST_ISSUE;
			ST_ISSUE:   if (adv && k_q == len_q - LEN_W'(1)) state_d = ST_COLLECT;
			default:    state_d = ST_COLLECT;
		endcase
	end

	always_comb begin
		in_stall = (state_q == ST_ISSUE);
		issue    = (state_q == ST_ISSUE) && adv;
	end

	// element decode for the read
	logic [LEN_W-1:0] pi, a1, a2, addr_a;
	logic             rot0, first0;
	logic [31:0]      tab_raddr_full;
	side_t            side0;

	always_comb begin
		rot0 = k_q < (pairs_q << 1);
		if (il_q) begin
			first0 = !k_q[0];
			pi     = k_q >> 1;
			a1     = {k_q[LEN_W-1:1], 1'b0};
			a2     = {k_q[LEN_W-1:1], 1'b1};
		end else begin
			first0 = k_q < pairs_q;
			pi     = first0 ? k_q : (k_q - pairs_q);
			a1     = pi;
			a2     = pi + pairs_q;
		end
		addr_a         = rot0 ? a1 : k_q;
		tab_raddr_full = 32'(pos_q) * 32'(PAIR_COLS) + 32'(pi);
		side0.rot      = rot0;
		side0.first    = first0;
		side0.err      = err_q;
		side0.last     = (k_q == len_q - LEN_W'(1));
		side0.idx      = k_q[5:0];
	end

	// row store, one copy per read port, and the cos/sin table
	logic signed [15:0] xa, xb;
	logic [31:0]        cs;

	rope_ram #(.WIDTH(16), .DEPTH(MAX_HEAD)) u_row_a (
		.clk   (clk),
		.we    (data_acc),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (x_value),
		.re    (adv),
		.raddr (addr_a[IDX_W-1:0]),
		.rdata (xa)
	);

	rope_ram #(.WIDTH(16), .DEPTH(MAX_HEAD)) u_row_b (
		.clk   (clk),
		.we    (data_acc),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (x_value),
		.re    (adv),
		.raddr (a2[IDX_W-1:0]),
		.rdata (xb)
	);

	rope_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr_full[TAB_AW-1:0]),
		.wdata ({cos_value, sin_value}),
		.re    (adv),
		.raddr (tab_raddr_full[TAB_AW-1:0]),
		.rdata (cs)
	);

	// emission pipeline
	logic               v_s1, v_s2, out_valid_q;
	side_t              side_s1, side_s2, side_q;
	logic signed [15:0] m1, m2;
	logic signed [31:0] prod1, prod2, p1_s2, p2_s2;
	logic signed [15:0] x_s2, y_q, y_rot, y_d;
	logic signed [32:0] sum;

	assign adv = !out_valid_q || !out_stall;

	always_comb begin
		if (side_s1.first) begin
			m1 = $signed(cs[31:16]);
			m2 = $signed(cs[15:0]);
		end else begin
			m1 = $signed(cs[15:0]);
			m2 = $signed(cs[31:16]);
		end
		prod1 = m1 * xa;
		prod2 = m2 * xb;
	end

	always_comb begin
		if (side_s2.first) begin
			sum = $signed({p1_s2[31], p1_s2}) - $signed({p2_s2[31], p2_s2});
		end else begin
			sum = $signed({p1_s2[31], p1_s2}) + $signed({p2_s2[31], p2_s2});
		end
		y_rot = round_sat(sum);
		if (side_s2.err) begin
			y_d = '0;
		end else if (side_s2.rot) begin
			y_d = y_rot;
		end else begin
			y_d = x_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side0;
			side_s2 <= side_s1;
			p1_s2   <= prod1;
			p2_s2   <= prod2;
			x_s2    <= xa;
			side_q  <= side_s2;
			y_q     <= y_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign y_value       = y_q;
	assign element_index = side_q.idx;
	assign range_error   = side_q.err;
	assign last          = side_q.last;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> y_value == 16'sd0)
		else $error("range error word with nonzero value");

	a_row_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside an emitted row");

	a_issue_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_ISSUE) |-> $past(row_done))
		else $error("emission started without a completed row");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> k_q < len_q)
		else $error("emission index beyond row length");
`endif

endmodule

// ----- rtl/rope_ram.sv -----
// generic simple dual-port ram with registered read
module rope_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- dv/rotary_position_embedding_core_tb.sv -----
// testbench for the rotary position embedding core: queued stimulus, predictor and checker
`timescale 1ns / 100ps

module rotary_position_embedding_core_tb;
	import rope_pkg::*;

	localparam int LIMIT = 200000;

	typedef struct {
		logic               act;
		logic [9:0]         trow;
		logic [4:0]         tcol;
		logic signed [15:0] c;
		logic signed [15:0] s;
		logic signed [15:0] x;
		logic [9:0]         pos;
		bit                 hold;
	} in_word_t;

	typedef struct {
		logic signed [15:0] y;
		logic [5:0]         idx;
		logic               err;
		logic               last;
	} out_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	cfg_idx_t           cfg_index = CFG_HEAD_LENGTH;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               action = ACT_LOAD;
	logic [9:0]         table_row = '0;
	logic [4:0]         table_column = '0;
	logic signed [15:0] cos_value = '0;
	logic signed [15:0] sin_value = '0;
	logic signed [15:0] x_value = '0;
	logic [9:0]         row_position = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] y_value;
	logic [5:0]         element_index;
	logic               range_error;
	logic               last;

	rotary_position_embedding_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .table_row(table_row), .table_column(table_column),
		.cos_value(cos_value), .sin_value(sin_value), .x_value(x_value),
		.row_position(row_position),
		.out_valid(out_valid), .out_stall(out_stall),
		.y_value(y_value), .element_index(element_index),
		.range_error(range_error), .last(last)
	);

	in_word_t           in_words[$];
	out_word_t          rotated_q[$];
	in_word_t           cur;
	int                 send_idle_pct = 28;
	int                 recv_stall_pct = 68;
	int                 mismatch_cnt = 0;
	int unsigned        cycle_cnt = 0;
	int                 queued_cnt = 0;
	bit                 hold_next = 1'b0;
	bit                 written_g [0:1023][0:31];

	// predictor state
	logic [6:0]         reg_head = 7'd64;
	logic [5:0]         reg_pairs = 6'd32;
	logic               reg_inter = 1'b0;
	logic [10:0]        reg_rows = 11'd1024;
	logic signed [15:0] cos_tab [0:1023][0:31];
	logic signed [15:0] sin_tab [0:1023][0:31];
	logic signed [15:0] row_mem [0:63];
	int                 elem_cnt = 0;
	logic [9:0]         held_pos = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int eff_len();
		int n;
		n = reg_head & 7'h7e;
		if (n < 2) n = 2;
		if (n > 64) n = 64;
		return n;
	endfunction

	function automatic int eff_pairs(input int len);
		int p;
		p = reg_pairs;
		if (p == 0 || p > len / 2) p = len / 2;
		return p;
	endfunction

	function automatic logic signed [15:0] mix_q15(input int a, input int x1, input int b,
			input int x2);
		longint acc;
		acc = longint'(a) * x1 + longint'(b) * x2 + 16384;
		acc = acc >>> 15;
		if (acc > 32767) return 16'sh7fff;
		if (acc < -32768) return 16'sh8000;
		return acc[15:0];
	endfunction

	task automatic embed_word(input in_word_t w);
		int len, np, i, i1, i2, k, c, s;
		logic err;
		logic signed [15:0] ybuf [0:63];
		out_word_t o;
		if (w.act == ACT_LOAD) begin
			cos_tab[w.trow][w.tcol] = w.c;
			sin_tab[w.trow][w.tcol] = w.s;
			return;
		end
		if (elem_cnt == 0) held_pos = w.pos;
		if (elem_cnt < 64) row_mem[elem_cnt] = w.x;
		elem_cnt++;
		len = eff_len();
		if (elem_cnt < len) return;
		elem_cnt = 0;
		np = eff_pairs(len);
		err = held_pos >= reg_rows;
		for (k = 0; k < len; k++) ybuf[k] = err ? 16'sd0 : row_mem[k];
		if (!err) begin
			for (i = 0; i < np; i++) begin
				i1 = reg_inter ? 2 * i : i;
				i2 = reg_inter ? 2 * i + 1 : i + np;
				c = cos_tab[held_pos][i];
				s = sin_tab[held_pos][i];
				ybuf[i1] = mix_q15(c, row_mem[i1], -s, row_mem[i2]);
				ybuf[i2] = mix_q15(s, row_mem[i1], c, row_mem[i2]);
			end
		end
		for (k = 0; k < len; k++) begin
			o.y = ybuf[k];
			o.idx = k[5:0];
			o.err = err;
			o.last = (k == len - 1);
			rotated_q.push_back(o);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic took, go;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			took = in_valid && !in_stall;
			if (took) embed_word(cur);
			if (!in_valid || took) begin
				go = in_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
				if (go && in_words[0].hold && rotated_q.size() != 0) go = 1'b0;
				if (go) begin
					cur = in_words.pop_front();
					action <= cur.act;
					table_row <= cur.trow;
					table_column <= cur.tcol;
					cos_value <= cur.c;
					sin_value <= cur.s;
					x_value <= cur.x;
					row_position <= cur.pos;
				end
				in_valid <= go;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_proc
		out_word_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (rotated_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: unexpected word, expected none, got y %0d index %0d", $time,
						y_value, element_index);
				end else begin
					e = rotated_q.pop_front();
					if (y_value !== e.y) begin
						mismatch_cnt++;
						$display("%0t: y_value expected %0d got %0d", $time, e.y, y_value);
					end
					if (element_index !== e.idx) begin
						mismatch_cnt++;
						$display("%0t: element_index expected %0d got %0d", $time, e.idx,
							element_index);
					end
					if (range_error !== e.err) begin
						mismatch_cnt++;
						$display("%0t: range_error expected %0b got %0b", $time, e.err,
							range_error);
					end
					if (last !== e.last) begin
						mismatch_cnt++;
						$display("%0t: last expected %0b got %0b", $time, e.last, last);
					end
				end
			end
			out_stall <= $urandom_range(0, 99) < recv_stall_pct;
		end
	end

	function automatic logic signed [15:0] rand_q15();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_word(input logic act, input logic [9:0] trow, input logic [4:0] tcol,
			input logic signed [15:0] c, input logic signed [15:0] s,
			input logic signed [15:0] x, input logic [9:0] pos);
		in_word_t w;
		w.act = act;
		w.trow = trow;
		w.tcol = tcol;
		w.c = c;
		w.s = s;
		w.x = x;
		w.pos = pos;
		w.hold = hold_next;
		hold_next = 1'b0;
		in_words.push_back(w);
		queued_cnt++;
	endtask

	task automatic push_load(input logic [9:0] trow, input logic [4:0] tcol,
			input logic signed [15:0] c, input logic signed [15:0] s);
		written_g[trow][tcol] = 1'b1;
		push_word(ACT_LOAD, trow, tcol, c, s, 16'($urandom), 10'($urandom));
	endtask

	task automatic push_data(input logic signed [15:0] x, input logic [9:0] pos);
		push_word(ACT_DATA, 10'($urandom), 5'($urandom), 16'($urandom), 16'($urandom), x,
			pos);
	endtask

	// tables for an in-range row are always filled before the row starts
	task automatic queue_row(input logic [9:0] pos);
		int len, np, i, k;
		len = eff_len();
		np = eff_pairs(len);
		if (pos < reg_rows) begin
			for (i = 0; i < np; i++) begin
				if (!written_g[pos][i]) push_load(pos, 5'(i), rand_q15(), rand_q15());
			end
		end
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0)
				push_load(10'($urandom_range(0, 1023)), 5'($urandom_range(0, 31)),
					rand_q15(), rand_q15());
			push_data(rand_q15(), k == 0 ? pos : 10'($urandom));
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[CFG_W-1:0];
		case (idx)
			CFG_HEAD_LENGTH: reg_head = v[6:0];
			CFG_ROTARY_PAIRS: reg_pairs = v[5:0];
			CFG_INTERLEAVED: reg_inter = v[0];
			CFG_TABLE_ROWS: reg_rows = v[10:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input int head, input int pairs, input int inter, input int rows);
		write_reg(CFG_HEAD_LENGTH, head);
		write_reg(CFG_ROTARY_PAIRS, pairs);
		write_reg(CFG_INTERLEAVED, inter);
		write_reg(CFG_TABLE_ROWS, rows);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		while (in_words.size() != 0 || in_valid || rotated_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(input int head, input int pairs, input int inter, input int rows,
			input int sidle, input int rstall, input int budget);
		int start;
		logic [9:0] pool [0:3];
		logic [9:0] pos;
		set_regs(head, pairs, inter, rows);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		pool[0] = 10'd0;
		pool[1] = 10'd1023;
		pool[2] = 10'($urandom_range(0, 1023));
		pool[3] = 10'($urandom_range(0, 1023));
		start = queued_cnt;
		while (queued_cnt - start < budget) begin
			if ($urandom_range(0, 9) < 6) pos = pool[$urandom_range(0, 3)];
			else pos = 10'($urandom_range(0, 1023));
			hold_next = ($urandom_range(0, 5) == 0);
			queue_row(pos);
		end
		drain();
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// odd head length, zero pairs, adjacent pairing, row limit above the table
		set_regs(3, 0, 1, 2047);
		hold_next = 1'b1;
		push_load(10'd1023, 5'd31, 16'sh7fff, 16'sh7fff);
		push_load(10'd1023, 5'd0, 16'sh8000, 16'sh8000);
		push_data(16'sh8000, 10'd1023);
		push_data(16'sh8000, 10'd0);
		push_load(10'd0, 5'd0, 16'sh8000, 16'sh7fff);
		push_data(16'sh7fff, 10'd0);
		push_data(16'sh7fff, 10'd1023);
		push_load(10'd2, 5'd0, 16'sd16384, 16'sd0);
		push_data(16'sd1, 10'd2);
		push_data(-16'sd1, 10'd2);
		push_load(10'd5, 5'd0, 16'sd0, 16'sd0);
		push_data(16'sd0, 10'd5);
		push_data(16'sd0, 10'd5);
		drain();

		// head length below two, pairs beyond half, single valid row
		set_regs(1, 5, 0, 1);
		hold_next = 1'b1;
		push_data(16'sd1234, 10'd1);
		push_data(-16'sd5, 10'd0);
		push_data(16'sh8000, 10'd0);
		push_data(16'sh7fff, 10'd1);
		push_data(16'sd77, 10'd1023);
		push_data(-16'sd77, 10'd0);
		drain();

		run_phase(127, 32, 1, 1024, 28, 68, 60);
		run_phase(8, 3, 0, 600, 28, 68, 70);
		run_phase(10, 0, 1, 1024, 68, 28, 70);
		run_phase(4, 63, 0, 1000, 68, 28, 60);
		run_phase(12, 1, 1, 300, 0, 0, 80);

		if (mismatch_cnt == 0 && rotated_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
